[hdl/delp_pkg.sv]
// Shared types, constants and helper functions for the dot edge list parser.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package delp_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LINE_BITS = 24;   // width of the internal line counter
    localparam int unsigned LINE_W    = 24;   // width of the reported line field

    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_UNDER = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

    localparam logic [LINE_BITS-1:0] LINE_MAX   = {LINE_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0] LINE_FIRST = LINE_BITS'(1);

    typedef enum logic [3:0] {
        PH_SRC_PRE   = 4'd0,
        PH_SRC       = 4'd1,
        PH_ARROW_PRE = 4'd2,
        PH_ARROW_HD  = 4'd3,
        PH_DST_PRE   = 4'd4,
        PH_DST       = 4'd5,
        PH_SEMI_PRE  = 4'd6,
        PH_ENDED     = 4'd7,
        PH_FAILED    = 4'd8
    } t_phase;

    typedef enum logic [2:0] {
        CM_BLANK = 3'd0,
        CM_BLOCK = 3'd1,
        CM_LINE  = 3'd2,
        CM_SLASH = 3'd3,
        CM_STAR  = 3'd4
    } t_comment;

    typedef enum logic [2:0] {
        EV_SRC  = 3'd0,
        EV_DST  = 3'd1,
        EV_EDGE = 3'd2,
        EV_END  = 3'd3,
        EV_ERR  = 3'd4,
        EV_EOF  = 3'd5
    } t_event;

    // Parser state carried from one byte to the next.
    typedef struct packed {
        t_phase               phase;
        t_comment             comment;
        logic [LINE_BITS-1:0] line;
    } t_state;

    // Result of one byte: whether an event is raised, and its contents.
    typedef struct packed {
        logic              valid;
        t_event            kind;
        logic [BYTE_W-1:0] char_value;
    } t_result;

    function automatic logic is_name(input logic [BYTE_W-1:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A) || (c == CH_UNDER);
    endfunction

    function automatic logic is_blank(input logic [BYTE_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

endpackage

`default_nettype wire

[hdl/delp_if.sv]
// Valid/ready channel interfaces for the input bytes and the parser events.
// Depends on delp_pkg for the field widths.
`default_nettype none

interface delp_in_if;
    logic                        valid;
    logic                        ready;
    logic [delp_pkg::BYTE_W-1:0] byte_value;
    logic                        end_of_input;

    modport source (output valid, output byte_value, output end_of_input, input ready);
    modport sink   (input valid, input byte_value, input end_of_input, output ready);
endinterface

interface delp_out_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  event_kind;
    logic [delp_pkg::BYTE_W-1:0] char_value;
    logic [delp_pkg::LINE_W-1:0] line;

    modport source (output valid, output event_kind, output char_value, output line,
                    input ready);
    modport sink   (input valid, input event_kind, input char_value, input line,
                    output ready);
endinterface

`default_nettype wire

[hdl/delp_step.sv]
// Combinational next-state and event logic of the parser for one byte.
// Depends on delp_pkg for the state, event types and character helpers.
`default_nettype none

module delp_step (
    input  var delp_pkg::t_state               i_state,
    input  var logic [delp_pkg::BYTE_W-1:0]    i_byte,
    input  var logic                           i_eof,
    output delp_pkg::t_state                   o_state,
    output delp_pkg::t_result                  o_result
);

    delp_pkg::t_phase              skim_phase;
    delp_pkg::t_comment            skim_cm;
    logic                          do_skim;
    logic                          sk_done;
    logic                          sk_slash;
    logic [delp_pkg::LINE_BITS-1:0] line_next;

    always_comb begin
        o_state           = i_state;
        o_result.valid    = 1'b0;
        o_result.kind     = delp_pkg::EV_SRC;
        o_result.char_value = '0;
        skim_phase        = i_state.phase;
        skim_cm           = i_state.comment;
        do_skim           = 1'b0;
        sk_done           = 1'b0;
        sk_slash          = 1'b0;
        line_next         = i_state.line;

        // First stage: phases that look at the byte directly.
        unique case (i_state.phase)
            delp_pkg::PH_ENDED, delp_pkg::PH_FAILED: begin
                do_skim = 1'b0;
            end
            delp_pkg::PH_SRC, delp_pkg::PH_DST: begin
                if (i_eof) begin
                    o_state.phase  = delp_pkg::PH_FAILED;
                    o_result.valid = 1'b1;
                    o_result.kind  = delp_pkg::EV_EOF;
                end else if (delp_pkg::is_name(i_byte)) begin
                    o_result.valid      = 1'b1;
                    o_result.kind       = (i_state.phase == delp_pkg::PH_SRC) ?
                                          delp_pkg::EV_SRC : delp_pkg::EV_DST;
                    o_result.char_value = i_byte;
                end else begin
                    skim_phase = (i_state.phase == delp_pkg::PH_SRC) ?
                                 delp_pkg::PH_ARROW_PRE : delp_pkg::PH_SEMI_PRE;
                    skim_cm    = delp_pkg::CM_BLANK;
                    do_skim    = 1'b1;
                end
            end
            delp_pkg::PH_ARROW_HD: begin
                if (i_eof) begin
                    o_state.phase  = delp_pkg::PH_FAILED;
                    o_result.valid = 1'b1;
                    o_result.kind  = delp_pkg::EV_EOF;
                end else if (i_byte == delp_pkg::CH_GT) begin
                    o_state.phase   = delp_pkg::PH_DST_PRE;
                    o_state.comment = delp_pkg::CM_BLANK;
                end else begin
                    o_state.phase       = delp_pkg::PH_FAILED;
                    o_result.valid      = 1'b1;
                    o_result.kind       = delp_pkg::EV_ERR;
                    o_result.char_value = i_byte;
                end
            end
            default: begin
                do_skim = 1'b1;
            end
        endcase

        if (do_skim) begin
            o_state.phase   = skim_phase;
            o_state.comment = skim_cm;

            // Blank and comment skipper.
            if (i_eof) begin
                if (skim_cm == delp_pkg::CM_SLASH) begin
                    sk_slash = 1'b1;
                end else begin
                    sk_done = 1'b1;
                end
            end else if (skim_cm == delp_pkg::CM_SLASH) begin
                if (i_byte == delp_pkg::CH_SLASH) begin
                    o_state.comment = delp_pkg::CM_LINE;
                end else if (i_byte == delp_pkg::CH_STAR) begin
                    o_state.comment = delp_pkg::CM_BLOCK;
                end else begin
                    sk_slash = 1'b1;
                end
            end else begin
                if (i_byte == delp_pkg::CH_LF && i_state.line != delp_pkg::LINE_MAX) begin
                    line_next = i_state.line + delp_pkg::LINE_FIRST;
                end
                unique case (skim_cm)
                    delp_pkg::CM_LINE: begin
                        if (i_byte == delp_pkg::CH_LF) begin
                            o_state.comment = delp_pkg::CM_BLANK;
                        end
                    end
                    delp_pkg::CM_BLOCK: begin
                        if (i_byte == delp_pkg::CH_STAR) begin
                            o_state.comment = delp_pkg::CM_STAR;
                        end
                    end
                    delp_pkg::CM_STAR: begin
                        if (i_byte == delp_pkg::CH_SLASH) begin
                            o_state.comment = delp_pkg::CM_BLANK;
                        end else if (i_byte != delp_pkg::CH_STAR) begin
                            o_state.comment = delp_pkg::CM_BLOCK;
                        end
                    end
                    default: begin
                        if (delp_pkg::is_blank(i_byte)) begin
                            sk_done = 1'b0;
                        end else if (i_byte == delp_pkg::CH_SLASH) begin
                            o_state.comment = delp_pkg::CM_SLASH;
                        end else begin
                            sk_done = 1'b1;
                        end
                    end
                endcase
            end
            o_state.line = line_next;

            if (sk_slash) begin
                o_state.comment     = delp_pkg::CM_BLANK;
                o_state.phase       = delp_pkg::PH_FAILED;
                o_result.valid      = 1'b1;
                o_result.kind       = delp_pkg::EV_ERR;
                o_result.char_value = delp_pkg::CH_SLASH;
            end else if (sk_done) begin
                o_state.comment = delp_pkg::CM_BLANK;
                // Act on the byte that ended the skip. A non-name byte before a
                // source name is handled as if the arrow were expected, and a
                // non-name byte before a destination name as if ';' were expected.
                if (skim_phase == delp_pkg::PH_SRC_PRE &&
                        (i_eof || i_byte == delp_pkg::CH_RBRACE)) begin
                    o_state.phase  = delp_pkg::PH_ENDED;
                    o_result.valid = 1'b1;
                    o_result.kind  = delp_pkg::EV_END;
                end else if (i_eof) begin
                    o_state.phase  = delp_pkg::PH_FAILED;
                    o_result.valid = 1'b1;
                    o_result.kind  = delp_pkg::EV_EOF;
                end else if (skim_phase == delp_pkg::PH_SRC_PRE &&
                             delp_pkg::is_name(i_byte)) begin
                    o_state.phase       = delp_pkg::PH_SRC;
                    o_result.valid      = 1'b1;
                    o_result.kind       = delp_pkg::EV_SRC;
                    o_result.char_value = i_byte;
                end else if (skim_phase == delp_pkg::PH_DST_PRE &&
                             delp_pkg::is_name(i_byte)) begin
                    o_state.phase       = delp_pkg::PH_DST;
                    o_result.valid      = 1'b1;
                    o_result.kind       = delp_pkg::EV_DST;
                    o_result.char_value = i_byte;
                end else if ((skim_phase == delp_pkg::PH_SRC_PRE ||
                              skim_phase == delp_pkg::PH_ARROW_PRE) &&
                             i_byte == delp_pkg::CH_MINUS) begin
                    o_state.phase = delp_pkg::PH_ARROW_HD;
                end else if ((skim_phase == delp_pkg::PH_DST_PRE ||
                              skim_phase == delp_pkg::PH_SEMI_PRE) &&
                             i_byte == delp_pkg::CH_SEMI) begin
                    o_state.phase  = delp_pkg::PH_SRC_PRE;
                    o_result.valid = 1'b1;
                    o_result.kind  = delp_pkg::EV_EDGE;
                end else begin
                    o_state.phase       = delp_pkg::PH_FAILED;
                    o_result.valid      = 1'b1;
                    o_result.kind       = delp_pkg::EV_ERR;
                    o_result.char_value = i_byte;
                end
            end
        end
    end

endmodule

`default_nettype wire

[hdl/dot_edge_list_parser.sv]
// Top level of the dot edge list parser: input register, parser state and result register.
// Depends on delp_pkg, the channel interfaces in delp_if.sv and the module delp_step.
`default_nettype none

// The parser takes the body of a dot digraph one byte per request and reports
// edge statements of the form "src -> dst ;". Each name byte comes out as a
// source or destination character event, followed by an edge event at the ';'.
// The end of the graph ('}' or end of input where a statement may begin), a
// syntax error and a premature end are reported once, with the line number, and
// after any of them the block swallows every further request without reply until
// reset. Blanks and both comment styles are skipped around names, but not inside
// the arrow. The block sustains one byte per clock cycle while the event side is
// ready: a byte is captured in the input register, and the whole parser update
// for it is one pass of combinational logic into the state and result registers,
// from which its event is presented on the output. When an event waits in the
// result register and is not being taken, the input register can still take one
// more byte if it is empty, and then the input stalls until the event is taken,
// whether or not that held byte raises an event.

module dot_edge_list_parser (
    input  var logic    i_clk,
    input  var logic    i_rst_n,
    delp_in_if.sink     i_in,
    delp_out_if.source  o_out
);

    // Input register.
    logic                           r_in_valid;
    logic [delp_pkg::BYTE_W-1:0]    r_byte;
    logic                           r_eof;

    // Parser state.
    delp_pkg::t_state               r_state;
    delp_pkg::t_state               n_state;
    delp_pkg::t_result              step_result;

    // Result register.
    logic                           r_out_valid;
    delp_pkg::t_event               r_kind;
    logic [delp_pkg::BYTE_W-1:0]    r_char;
    logic [delp_pkg::LINE_W-1:0]    r_line;

    logic                           out_free;
    logic                           advance;
    logic                           in_take;

    // The held byte is processed once the result register can take its event.
    assign out_free = !r_out_valid || o_out.ready;
    assign advance  = r_in_valid && out_free;
    assign in_take  = i_in.valid && i_in.ready;

    assign i_in.ready = !r_in_valid || advance;

    delp_step u_step (
        .i_state  (r_state),
        .i_byte   (r_byte),
        .i_eof    (r_eof),
        .o_state  (n_state),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_byte <= i_in.byte_value;
            r_eof  <= i_in.end_of_input;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase   <= delp_pkg::PH_SRC_PRE;
            r_state.comment <= delp_pkg::CM_BLANK;
            r_state.line    <= delp_pkg::LINE_FIRST;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step_result.valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // The reported line carries the count after this byte's newline, if any.
    always_ff @(posedge i_clk) begin
        if (advance && step_result.valid) begin
            r_kind <= step_result.kind;
            r_char <= step_result.char_value;
            r_line <= delp_pkg::LINE_W'(n_state.line);
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.event_kind = r_kind;
    assign o_out.char_value = r_char;
    assign o_out.line       = r_line;

endmodule

`default_nettype wire

[tb/sv/tb_dot_edge_list_parser.sv]
// Self-checking bench for dot_edge_list_parser: a byte-by-byte predictor of the parser,
// a queue of awaited events and random valid/ready pacing on both channels.
// Depends on delp_pkg, the channel interfaces in delp_if.sv and the RTL of the block.

package delp_check_pkg;
    import delp_pkg::*;

    typedef enum logic [1:0] {SKIM_MORE, SKIM_DONE, SKIM_SLASH} t_skim;

    typedef struct packed {
        t_event             kind;
        logic [BYTE_W-1:0]  chr;
        logic [LINE_W-1:0]  line_no;
    } t_parse_event;

    // Follows the parser byte by byte and keeps the events it must raise, oldest first.
    class edge_event_ledger;
        t_phase                phase;
        t_comment              comment;
        logic [LINE_BITS-1:0]  line_no;
        t_parse_event          awaited[$];
        int unsigned           errors;

        function new();
            phase   = PH_SRC_PRE;
            comment = CM_BLANK;
            line_no = LINE_FIRST;
            errors  = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function bit name_byte(logic [BYTE_W-1:0] c);
            return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                   (c >= "a" && c <= "z") || c == CH_UNDER;
        endfunction

        function void raise(t_event kind, logic [BYTE_W-1:0] chr);
            awaited.push_back('{kind: kind, chr: chr, line_no: LINE_W'(line_no)});
        endfunction

        function void stop_with(t_phase last, t_event kind, logic [BYTE_W-1:0] chr);
            phase = last;
            raise(kind, chr);
        endfunction

        // Blank and comment skipping; line feeds are counted here and nowhere else.
        function t_skim skim(logic [BYTE_W-1:0] c, bit eof);
            if (eof) begin
                if (comment == CM_SLASH) return SKIM_SLASH;
                comment = CM_BLANK;
                return SKIM_DONE;
            end
            if (comment == CM_SLASH) begin
                if (c == CH_SLASH) begin
                    comment = CM_LINE;
                    return SKIM_MORE;
                end
                if (c == CH_STAR) begin
                    comment = CM_BLOCK;
                    return SKIM_MORE;
                end
                return SKIM_SLASH;
            end
            if (c == CH_LF && line_no != LINE_MAX) line_no = line_no + 1'b1;
            case (comment)
                CM_LINE: begin
                    if (c == CH_LF) comment = CM_BLANK;
                    return SKIM_MORE;
                end
                CM_BLOCK: begin
                    if (c == CH_STAR) comment = CM_STAR;
                    return SKIM_MORE;
                end
                CM_STAR: begin
                    if (c == CH_SLASH) comment = CM_BLANK;
                    else if (c != CH_STAR) comment = CM_BLOCK;
                    return SKIM_MORE;
                end
                default: begin
                    if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF)
                        return SKIM_MORE;
                    if (c == CH_SLASH) begin
                        comment = CM_SLASH;
                        return SKIM_MORE;
                    end
                    return SKIM_DONE;
                end
            endcase
        endfunction

        function void note_byte(logic [BYTE_W-1:0] c, bit eof);
            t_skim sk;
            if (phase == PH_ENDED || phase == PH_FAILED) return;
            if (phase == PH_SRC || phase == PH_DST) begin
                if (eof) begin
                    stop_with(PH_FAILED, EV_EOF, '0);
                    return;
                end
                if (name_byte(c)) begin
                    raise(phase == PH_SRC ? EV_SRC : EV_DST, c);
                    return;
                end
                phase   = (phase == PH_SRC) ? PH_ARROW_PRE : PH_SEMI_PRE;
                comment = CM_BLANK;
            end else if (phase == PH_ARROW_HD) begin
                if (eof) begin
                    stop_with(PH_FAILED, EV_EOF, '0);
                    return;
                end
                if (c == CH_GT) begin
                    phase   = PH_DST_PRE;
                    comment = CM_BLANK;
                    return;
                end
                stop_with(PH_FAILED, EV_ERR, c);
                return;
            end
            sk = skim(c, eof);
            if (sk == SKIM_MORE) return;
            comment = CM_BLANK;
            if (sk == SKIM_SLASH) begin
                stop_with(PH_FAILED, EV_ERR, CH_SLASH);
                return;
            end
            // The byte that ended the skip; optional names fall through to the next phase.
            if (phase == PH_SRC_PRE) begin
                if (eof || c == CH_RBRACE) begin
                    stop_with(PH_ENDED, EV_END, '0);
                    return;
                end
                if (name_byte(c)) begin
                    phase = PH_SRC;
                    raise(EV_SRC, c);
                    return;
                end
                phase = PH_ARROW_PRE;
            end else if (phase == PH_DST_PRE && !eof) begin
                if (name_byte(c)) begin
                    phase = PH_DST;
                    raise(EV_DST, c);
                    return;
                end
                phase = PH_SEMI_PRE;
            end
            if (eof) begin
                stop_with(PH_FAILED, EV_EOF, '0);
                return;
            end
            if (phase == PH_ARROW_PRE) begin
                if (c == CH_MINUS) phase = PH_ARROW_HD;
                else stop_with(PH_FAILED, EV_ERR, c);
                return;
            end
            if (c == CH_SEMI) begin
                phase = PH_SRC_PRE;
                raise(EV_EDGE, '0);
            end else begin
                stop_with(PH_FAILED, EV_ERR, c);
            end
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH: %s", msg);
        endtask

        task check_event(logic [2:0] kind, logic [BYTE_W-1:0] chr, logic [LINE_W-1:0] ln);
            t_parse_event want;
            if (awaited.size() == 0) begin
                report($sformatf("event kind %0d char %02h line %0d with none awaited",
                                 kind, chr, ln));
                return;
            end
            want = awaited.pop_front();
            if (kind !== want.kind)
                report($sformatf("kind %0d, awaited %s", kind, want.kind.name()));
            if (chr !== want.chr)
                report($sformatf("char %02h, awaited %02h (%s)", chr, want.chr,
                                 want.kind.name()));
            if (ln !== want.line_no)
                report($sformatf("line %0d, awaited %0d (%s)", ln, want.line_no,
                                 want.kind.name()));
        endtask
    endclass
endpackage

module tb_dot_edge_list_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import delp_pkg::*;
    import delp_check_pkg::*;

    // The watchdog allows far more than the longest quiet stretch of a correct run,
    // which is the deliberate hold-off of the event side.
    localparam int IDLE_LIMIT      = 4000;
    localparam int HOLD_OFF_CYCLES = 240;
    localparam int TAIL_CYCLES     = 20;
    localparam int RANDOM_ITEMS    = 1600;

    localparam int SIDE_SEND = 0;
    localparam int SIDE_RECV = 1;

    typedef enum int {PACE_FULL, PACE_LIGHT, PACE_HEAVY} t_pace;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        bit                eof;
    } t_text_byte;

    logic i_clk;
    logic i_rst_n;

    delp_in_if  in_ch ();
    delp_out_if out_ch ();

    dot_edge_list_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    edge_event_ledger ledger;
    t_text_byte       text_q[$];
    t_pace            pace[2];
    int               pace_left[2];
    int               idle_cycles;
    int               stall_index;
    int               drain_index;
    bit               hold_events;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Text generation. The whole run is a single graph, because every
    // way of ending it is sticky and reset is applied only once, so the
    // bulk of the text is well-formed statements and the run closes with
    // one randomly chosen ending followed by bytes that must be ignored.
    // ------------------------------------------------------------------

    function automatic void put(logic [BYTE_W-1:0] c);
        text_q.push_back('{value: c, eof: 1'b0});
    endfunction

    function automatic void put_eof();
        text_q.push_back('{value: BYTE_W'($urandom_range(0, 255)), eof: 1'b1});
    endfunction

    function automatic void put_str(string s);
        for (int k = 0; k < s.len(); k++) put(s[k]);
    endfunction

    // Random bytes of any value, which is where the top bit of the byte gets exercised.
    // A star is never followed by a slash, so the comment cannot close early.
    function automatic void put_block_comment();
        int n;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] prev;
        n = $urandom_range(0, 6);
        prev = '0;
        put_str("/*");
        for (int k = 0; k < n; k++) begin
            b = BYTE_W'($urandom_range(0, 255));
            if (b == CH_SLASH && prev == CH_STAR) b = "x";
            put(b);
            prev = b;
        end
        repeat ($urandom_range(1, 3)) put(CH_STAR);
        put(CH_SLASH);
    endfunction

    function automatic void put_line_comment();
        logic [BYTE_W-1:0] b;
        put_str("//");
        repeat ($urandom_range(0, 6)) begin
            b = BYTE_W'($urandom_range(0, 255));
            put(b == CH_LF ? 8'hFF : b);
        end
        put(CH_LF);
    endfunction

    function automatic void put_filler();
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 5))
                0: put(CH_SPACE);
                1: put($urandom_range(0, 1) ? CH_LF : ($urandom_range(0, 1) ? CH_TAB : CH_CR));
                2: put_block_comment();
                3: put_line_comment();
                default: ;
            endcase
        end
    endfunction

    function automatic logic [BYTE_W-1:0] random_name_byte();
        int k;
        k = $urandom_range(0, 62);
        if (k < 10) return BYTE_W'("0" + k);
        if (k < 36) return BYTE_W'("A" + k - 10);
        if (k < 62) return BYTE_W'("a" + k - 36);
        return CH_UNDER;
    endfunction

    function automatic void put_name();
        if ($urandom_range(0, 7) == 0) return;
        repeat ($urandom_range(1, 5)) put(random_name_byte());
    endfunction

    function automatic void put_statement();
        put_filler();
        put_name();
        put_filler();
        put(CH_MINUS);
        put(CH_GT);
        put_filler();
        put_name();
        put_filler();
        put(CH_SEMI);
    endfunction

    function automatic logic [BYTE_W-1:0] byte_other_than(logic [BYTE_W-1:0] a,
                                                           logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        do c = BYTE_W'($urandom_range(0, 255)); while (c == a || c == b);
        return c;
    endfunction

    // One of the ways a graph can stop, chosen by the seed.
    function automatic void put_ending();
        case ($urandom_range(0, 11))
            0: begin
                put_filler();
                put(CH_RBRACE);
            end
            1: begin
                put_filler();
                put_eof();
            end
            2: begin
                put(random_name_byte());
                put_eof();
            end
            3: begin
                // Lone slash inside a statement.
                put(random_name_byte());
                put(CH_SLASH);
                put(byte_other_than(CH_SLASH, CH_STAR));
            end
            4: begin
                // Bad arrow head, sometimes a line feed, which must not be counted.
                put(random_name_byte());
                put(CH_MINUS);
                put($urandom_range(0, 1) ? CH_LF : byte_other_than(CH_GT, CH_GT));
            end
            5: begin
                // End of input inside a comment in mid statement.
                put_str("a /* ");
                put(BYTE_W'($urandom_range(0, 255)));
                put_eof();
            end
            6: begin
                put_str("a->b");
                put(BYTE_W'($urandom_range(128, 255)));
            end
            7: begin
                put_str("a->");
                put_eof();
            end
            8: begin
                put(CH_SPACE);
                put($urandom_range(0, 1) ? 8'h7B : BYTE_W'($urandom_range(128, 255)));
            end
            9: begin
                put_str("a->b /");
                put_eof();
            end
            10: begin
                put_str("/* c");
                put_eof();
            end
            default: begin
                put_str("a->");
                put(CH_RBRACE);
            end
        endcase
        // Whatever follows the end of the graph is swallowed without an event.
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 3) == 0) put_eof();
            else put(BYTE_W'($urandom_range(0, 255)));
        end
        put_eof();
    endfunction

    function automatic void build_text();
        int directed_len;
        // Directed opening: name extremes, empty names, both comment styles, a run of
        // stars closing a comment, and high and zero bytes inside a line comment.
        put_str("aZ_09->z;");
        put(CH_TAB);
        put_str("->;/***/A");
        put(CH_CR);
        put_str("//");
        put(8'hFF);
        put(8'h00);
        put(CH_LF);
        put_str("->_;");
        directed_len = text_q.size();
        while (text_q.size() < directed_len + RANDOM_ITEMS) put_statement();
        put_ending();
        stall_index = directed_len + 150;
        drain_index = text_q.size() / 2;
    endfunction

    // ------------------------------------------------------------------
    // Pacing: each side switches now and then between running flat out,
    // pausing occasionally and pausing often.
    // ------------------------------------------------------------------

    function automatic int draw_gap(int side);
        if (pace_left[side] == 0) begin
            pace[side]      = t_pace'($urandom_range(0, 2));
            pace_left[side] = $urandom_range(20, 60);
        end
        pace_left[side]--;
        case (pace[side])
            PACE_FULL:  return 0;
            PACE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
            default:    return $urandom_range(0, 14);
        endcase
    endfunction

    // Offers the text one byte per request. Valid stays high between back-to-back
    // requests, so it is never lowered and raised within one time step.
    task automatic send_text();
        int gap;
        for (int i = 0; i < text_q.size(); i++) begin
            if (i == stall_index) begin
                // Ask the event side to hold off while this side runs at full rate,
                // so that the block fills up and refuses input for a while.
                hold_events     = 1'b1;
                pace[SIDE_SEND] = PACE_FULL;
                pace_left[SIDE_SEND] = 80;
            end
            if (i == drain_index) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (ledger.pending() != 0) @(posedge i_clk);
            end
            gap = draw_gap(SIDE_SEND);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            in_ch.valid        <= 1'b1;
            in_ch.byte_value   <= text_q[i].value;
            in_ch.end_of_input <= text_q[i].eof;
            @(posedge i_clk);
            while (!in_ch.ready) @(posedge i_clk);
            ledger.note_byte(text_q[i].value, text_q[i].eof);
        end
        in_ch.valid <= 1'b0;
    endtask

    // Takes events with random stalls and checks each against the oldest awaited one.
    task automatic receive_events();
        int gap;
        forever begin
            if (hold_events) begin
                hold_events = 1'b0;
                gap = HOLD_OFF_CYCLES;
            end else begin
                gap = draw_gap(SIDE_RECV);
            end
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            ledger.check_event(out_ch.event_kind, out_ch.char_value, out_ch.line);
        end
    endtask

    // The run is abandoned if neither channel completes a request for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        ledger      = new();
        hold_events = 1'b0;
        idle_cycles = 0;
        pace_left[SIDE_SEND] = 0;
        pace_left[SIDE_RECV] = 0;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.byte_value   <= '0;
        in_ch.end_of_input <= 1'b0;
        out_ch.ready       <= 1'b0;
        build_text();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            receive_events();
        join_none
        send_text();
        // Wait for the last awaited event, then give a stray one time to show up.
        while (ledger.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (ledger.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

[dot_edge_list_parser.f]
hdl/delp_pkg.sv
hdl/delp_if.sv
hdl/delp_step.sv
hdl/dot_edge_list_parser.sv
tb/sv/tb_dot_edge_list_parser.sv
